// ===== src/minv3_pkg.sv =====
// Shared constants and types for the 3x3 matrix inverse pipeline.
// No dependencies.
package minv3_pkg;

  localparam int FracBits = 16;
  localparam int ElemW    = 32;
  localparam int CofW     = 64;
  localparam int DetW     = 98;
  localparam int NumW     = CofW + 2 * FracBits;
  localparam int QW       = 33;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;
  typedef logic signed [DetW-1:0]  det_t;
  typedef logic [DetW-1:0]         dmag_t;
  typedef logic [NumW-1:0]         num_t;
  typedef logic [QW-1:0]           quo_t;

  localparam elem_t SatMax = 32'sh7FFF_FFFF;
  localparam elem_t SatMin = 32'sh8000_0000;

endpackage

// ===== src/minv3_cof.sv =====
// Cofactor stage: products registered, then differences registered.
// Depends on minv3_pkg.
module minv3_cof (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 v_i,
  input  minv3_pkg::elem_t     m_i [9],
  output logic                 v_o,
  output minv3_pkg::elem_t     row0_o [3],
  output minv3_pkg::cof_t      cof_o [9]
);

  logic             v1_q;
  minv3_pkg::cof_t  pa_q [9];
  minv3_pkg::cof_t  pb_q [9];
  minv3_pkg::elem_t r1_q [3];
  minv3_pkg::elem_t r2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v_o  <= 1'b0;
    end else if (en_i) begin
      v1_q <= v_i;
      v_o  <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa_q[i*3+j] <= m_i[((i+1)%3)*3 + (j+1)%3] * m_i[((i+2)%3)*3 + (j+2)%3];
          pb_q[i*3+j] <= m_i[((i+1)%3)*3 + (j+2)%3] * m_i[((i+2)%3)*3 + (j+1)%3];
        end
      end
      for (int j = 0; j < 3; j++) begin
        r1_q[j]   <= m_i[j];
        row0_o[j] <= r1_q[j];
      end
      for (int k = 0; k < 9; k++) cof_o[k] <= pa_q[k] - pb_q[k];
    end
  end

endmodule

// ===== src/minv3_det.sv =====
// Determinant stage: three 64x32 products split in halves, then summed.
// Depends on minv3_pkg.
module minv3_det (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              v_i,
  input  minv3_pkg::elem_t  row0_i [3],
  input  minv3_pkg::cof_t   cof_i [9],
  output logic              v_o,
  output minv3_pkg::dmag_t  dmag_o,
  output logic              dneg_o,
  output logic              dzero_o,
  output minv3_pkg::cof_t   cof_o [9]
);

  logic                   v1_q, v2_q;
  logic signed [64:0]     lo_q [3];
  logic signed [64:0]     hi_q [3];
  minv3_pkg::cof_t        c1_q [9];
  minv3_pkg::cof_t        c2_q [9];
  minv3_pkg::det_t        det_q;
  minv3_pkg::det_t        sum;

  always_comb begin
    sum = '0;
    for (int j = 0; j < 3; j++) begin
      sum = sum + minv3_pkg::det_t'(lo_q[j]) + (minv3_pkg::det_t'(hi_q[j]) <<< 32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v_o  <= 1'b0;
    end else if (en_i) begin
      v1_q <= v_i;
      v2_q <= v1_q;
      v_o  <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= $signed({1'b0, cof_i[j][31:0]}) * row0_i[j];
        hi_q[j] <= $signed(cof_i[j][63:32]) * row0_i[j];
      end
      det_q   <= sum;
      dneg_o  <= det_q[minv3_pkg::DetW-1];
      dzero_o <= (det_q == '0);
      dmag_o  <= det_q[minv3_pkg::DetW-1] ? minv3_pkg::dmag_t'(-det_q)
                                          : minv3_pkg::dmag_t'(det_q);
      c1_q  <= cof_i;
      c2_q  <= c1_q;
      cof_o <= c2_q;
    end
  end

endmodule

// ===== src/minv3_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for nine lanes.
// Depends on minv3_pkg.
module minv3_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              v_i,
  input  minv3_pkg::dmag_t  dmag_i,
  input  logic              dneg_i,
  input  logic              dzero_i,
  input  minv3_pkg::cof_t   cof_i [9],
  output logic              v_o,
  output minv3_pkg::elem_t  inv_o [9],
  output logic              singular_o,
  output logic              overflow_o
);

  localparam int NW = minv3_pkg::NumW;
  localparam int RW = minv3_pkg::DetW + 1;
  localparam int Stages = NW;

  logic             v_q    [Stages+1];
  minv3_pkg::dmag_t d_q    [Stages+1];
  logic             dneg_q [Stages+1];
  logic             dz_q   [Stages+1];
  logic [RW-1:0]    rem_q  [Stages+1][9];
  minv3_pkg::num_t  num_q  [Stages+1][9];
  logic             big_q  [Stages+1][9];
  minv3_pkg::quo_t  q_q    [Stages+1][9];
  logic             cn_q   [Stages+1][9];

  always_comb begin
    v_q[0]    = v_i;
    d_q[0]    = dmag_i;
    dneg_q[0] = dneg_i;
    dz_q[0]   = dzero_i;
    for (int k = 0; k < 9; k++) begin
      cn_q[0][k]  = cof_i[k][minv3_pkg::CofW-1];
      num_q[0][k] = minv3_pkg::num_t'(cof_i[k][minv3_pkg::CofW-1]
                      ? -cof_i[k] : cof_i[k]) << (2 * minv3_pkg::FracBits);
      rem_q[0][k] = '0;
      big_q[0][k] = 1'b0;
      q_q[0][k]   = '0;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [RW-1:0] sh [9];
    logic          ge [9];
    always_comb begin
      for (int k = 0; k < 9; k++) begin
        sh[k] = {rem_q[s][k][RW-2:0], num_q[s][k][NW-1]};
        ge[k] = (sh[k] >= {1'b0, d_q[s]});
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s+1] <= 1'b0;
      else if (en_i) v_q[s+1] <= v_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s+1]    <= d_q[s];
        dneg_q[s+1] <= dneg_q[s];
        dz_q[s+1]   <= dz_q[s];
        for (int k = 0; k < 9; k++) begin
          rem_q[s+1][k] <= ge[k] ? sh[k] - {1'b0, d_q[s]} : sh[k];
          num_q[s+1][k] <= num_q[s][k] << 1;
          cn_q[s+1][k]  <= cn_q[s][k];
          q_q[s+1][k]   <= {q_q[s][k][minv3_pkg::QW-2:0], ge[k]};
          big_q[s+1][k] <= big_q[s][k] | q_q[s][k][minv3_pkg::QW-1];
        end
      end
    end
  end

  logic            neg [9];
  logic            sat [9];
  minv3_pkg::elem_t val [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      neg[k] = cn_q[Stages][k] != dneg_q[Stages];
      if (neg[k]) begin
        sat[k] = big_q[Stages][k] || (q_q[Stages][k] > minv3_pkg::quo_t'(33'h0_8000_0000));
        val[k] = sat[k] ? minv3_pkg::SatMin : -minv3_pkg::elem_t'(q_q[Stages][k][31:0]);
      end else begin
        sat[k] = big_q[Stages][k] || (q_q[Stages][k] > minv3_pkg::quo_t'(33'h0_7FFF_FFFF));
        val[k] = sat[k] ? minv3_pkg::SatMax : minv3_pkg::elem_t'(q_q[Stages][k][31:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_o <= 1'b0;
    else if (en_i) v_o <= v_q[Stages];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      singular_o <= dz_q[Stages];
      overflow_o <= !dz_q[Stages] && (sat[0] | sat[1] | sat[2] | sat[3] | sat[4]
                                      | sat[5] | sat[6] | sat[7] | sat[8]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          inv_o[i*3+j] <= dz_q[Stages] ? '0 : val[j*3+i];
        end
      end
    end
  end

endmodule

// ===== src/matrix_inverse_3x3_unit.sv =====
// 3x3 matrix inverse by adjugate, signed Q16.16, saturating.
// Pipeline: cofactor, determinant, divider and output registers, in that order.
// Throughput: one item per cycle while the output does not stall.
// The whole pipeline advances together; it holds when the output stalls.
// Reset clears the valid bits only. Depends on minv3_pkg and submodules.
module matrix_inverse_3x3_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [31:0]      m00_i, m01_i, m02_i,
  input  logic signed [31:0]      m10_i, m11_i, m12_i,
  input  logic signed [31:0]      m20_i, m21_i, m22_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [31:0]      inv00_o, inv01_o, inv02_o,
  output logic signed [31:0]      inv10_o, inv11_o, inv12_o,
  output logic signed [31:0]      inv20_o, inv21_o, inv22_o,
  output logic                    singular_o,
  output logic                    overflow_o
);

  logic              en;
  minv3_pkg::elem_t  m [9];
  minv3_pkg::elem_t  row0 [3];
  minv3_pkg::cof_t   cof_a [9];
  minv3_pkg::cof_t   cof_b [9];
  minv3_pkg::dmag_t  dmag;
  minv3_pkg::elem_t  inv [9];
  logic              v_a, v_b, dneg, dzero;

  assign en      = ready_i || !valid_o;
  assign ready_o = en;

  assign m = '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};

  minv3_cof u_cof (
    .clk_i, .rst_ni, .en_i(en), .v_i(valid_i), .m_i(m),
    .v_o(v_a), .row0_o(row0), .cof_o(cof_a)
  );

  minv3_det u_det (
    .clk_i, .rst_ni, .en_i(en), .v_i(v_a), .row0_i(row0), .cof_i(cof_a),
    .v_o(v_b), .dmag_o(dmag), .dneg_o(dneg), .dzero_o(dzero), .cof_o(cof_b)
  );

  minv3_div u_div (
    .clk_i, .rst_ni, .en_i(en), .v_i(v_b), .dmag_i(dmag), .dneg_i(dneg),
    .dzero_i(dzero), .cof_i(cof_b), .v_o(valid_o), .inv_o(inv),
    .singular_o, .overflow_o
  );

  assign inv00_o = inv[0];
  assign inv01_o = inv[1];
  assign inv02_o = inv[2];
  assign inv10_o = inv[3];
  assign inv11_o = inv[4];
  assign inv12_o = inv[5];
  assign inv20_o = inv[6];
  assign inv21_o = inv[7];
  assign inv22_o = inv[8];

endmodule
